>>> src/periodic_radial_blend_weight_macros.svh
// Assertion helpers shared by the blend weight RTL.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef PERIODIC_RADIAL_BLEND_WEIGHT_MACROS_SVH
`define PERIODIC_RADIAL_BLEND_WEIGHT_MACROS_SVH

// General property, sampled on i_clk and switched off during reset.
`define PRBW_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication form.
`define PRBW_IMPLY(label, ante, cons, msg) \
    `PRBW_CHECK(label, ante |-> cons, msg)

`endif

>>> src/prbw_pkg.sv
`default_nettype none

package prbw_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_BOX_X   = 4'd0;
    localparam t_cfg_idx REG_BOX_Y   = 4'd1;
    localparam t_cfg_idx REG_BOX_Z   = 4'd2;
    localparam t_cfg_idx REG_R_INNER = 4'd3;
    localparam t_cfg_idx REG_R_OUTER = 4'd4;
    localparam t_cfg_idx REG_SLOPE   = 4'd5;
    localparam t_cfg_idx REG_S_MIN   = 4'd6;
    localparam t_cfg_idx REG_S_MAX   = 4'd7;

    // field widths
    localparam int LEN_W    = 31;   // box lengths and radii, Q11.20
    localparam int SLOPE_W  = 24;   // Q8.16
    localparam int WEIGHT_W = 17;   // Q1.16
    localparam int MAG_W    = 32;   // per-axis magnitude, capped at 2^31
    localparam int SQ_W     = 64;   // squared distance, Q24.40

    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;

    // zone codes
    typedef logic [1:0] t_zone;
    localparam t_zone ZONE_INSIDE  = 2'd0;
    localparam t_zone ZONE_SHELL   = 2'd1;
    localparam t_zone ZONE_OUTSIDE = 2'd2;

    // square root pipeline: the radicand of a shell point is below r_outer^2 < 2^62
    localparam int RAD_W          = 62;
    localparam int ROOT_W         = RAD_W / 2;
    localparam int REM_W          = ROOT_W + 3;
    localparam int SQRT_ITERS     = ROOT_W;
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = (SQRT_ITERS + SQRT_PER_STAGE - 1) / SQRT_PER_STAGE;

    // accept edge to the edge that samples the result strobe
    localparam int PIPE_LAT = SQRT_STAGES + 8;

    typedef struct packed {
        logic              valid;
        t_zone             tag;
        logic [RAD_W-1:0]  rad;
    } t_sqrt_in;

    typedef struct packed {
        logic              valid;
        t_zone             tag;
        logic [ROOT_W-1:0] root;
    } t_sqrt_out;

endpackage

`default_nettype wire

>>> src/periodic_radial_blend_weight.sv
`default_nettype none

// Channel   Dir  Beat marked by                 Payload
// -------   ---  -----------------------------  --------------------------------------
// point in  in   start high while busy low      i_point_x/y/z, i_center_x/y/z
// result    out  o_done high for one cycle      o_weight, o_zone
// config    in   i_cfg_valid && o_cfg_ready     i_cfg_index, i_cfg_data
//
// One point is taken every cycle; busy never rises, as nothing upstream of the
// pipeline has to wait. A point's result strobes after it has passed S1 to S6, the square
// root pipeline (two root bits per stage), S7 and the output register of S8.
// Reset is synchronous, active low, clears all valid bits and loads register defaults.
// The receiver cannot stall, so the pipeline never holds and nothing needs a skid stage.

`include "periodic_radial_blend_weight_macros.svh"

module periodic_radial_blend_weight import prbw_pkg::*; #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // point channel
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_point_z,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic signed [COORD_BITS-1:0] i_center_z,
    // result channel
    output logic                         o_done,
    output logic [WEIGHT_W-1:0]          o_weight,
    output t_zone                        o_zone,
    // register write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  t_cfg_idx                     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // signed difference width, and a width that also holds a box length plus sign
    localparam int DW = COORD_BITS + 1;
    localparam int SW = ((DW > LEN_W) ? DW : LEN_W) + 1;
    localparam logic [SW-1:0] MAG_CAP = SW'(64'd2147483648);
    localparam logic [MAG_W-1:0] MAG_SAT = 32'h8000_0000;
    localparam logic [55:0] ROUND_HALF = 56'd524288;

    // ---------------------------------------------------------------- registers
    logic [LEN_W-1:0]    r_box [3];
    logic [LEN_W-1:0]    r_ri;
    logic [LEN_W-1:0]    r_ro;
    logic [SLOPE_W-1:0]  r_slope;
    logic [WEIGHT_W-1:0] r_s_min;
    logic [WEIGHT_W-1:0] r_s_max;

    // squares of the radii, refreshed every cycle; config is to move only while idle (the block does not enforce it)
    logic [2*LEN_W-1:0]  r_ri_sq;
    logic [2*LEN_W-1:0]  r_ro_sq;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box[0] <= 31'd1048576;
            r_box[1] <= 31'd1048576;
            r_box[2] <= 31'd1048576;
            r_ri     <= '0;
            r_ro     <= 31'd1048576;
            r_slope  <= 24'd65536;
            r_s_min  <= '0;
            r_s_max  <= ONE_Q16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_BOX_X:   r_box[0] <= i_cfg_data[LEN_W-1:0];
                REG_BOX_Y:   r_box[1] <= i_cfg_data[LEN_W-1:0];
                REG_BOX_Z:   r_box[2] <= i_cfg_data[LEN_W-1:0];
                REG_R_INNER: r_ri     <= i_cfg_data[LEN_W-1:0];
                REG_R_OUTER: r_ro     <= i_cfg_data[LEN_W-1:0];
                REG_SLOPE:   r_slope  <= i_cfg_data[SLOPE_W-1:0];
                REG_S_MIN:   r_s_min  <= i_cfg_data[WEIGHT_W-1:0];
                REG_S_MAX:   r_s_max  <= i_cfg_data[WEIGHT_W-1:0];
                default: ;   // unmapped index: write dropped
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ri_sq <= (2*LEN_W)'(r_ri) * (2*LEN_W)'(r_ri);
        r_ro_sq <= (2*LEN_W)'(r_ro) * (2*LEN_W)'(r_ro);
    end

    // ---------------------------------------------------------------- S1: capture
    logic                         r_s1_valid;
    logic signed [COORD_BITS-1:0] r_s1_p [3];
    logic signed [COORD_BITS-1:0] r_s1_c [3];

    // ---------------------------------------------------------------- S2: |p - c|
    logic                         r_s2_valid;
    logic [DW-1:0]                r_s2_abs [3];
    logic signed [DW-1:0]         w_diff [3];
    logic [DW-1:0]                w_abs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_diff[i] = {r_s1_p[i][COORD_BITS-1], r_s1_p[i]}
                      - {r_s1_c[i][COORD_BITS-1], r_s1_c[i]};
            w_abs[i]  = w_diff[i][DW-1] ? DW'(-w_diff[i]) : DW'(w_diff[i]);
        end
    end

    // ---------------------------------------------------------------- S3: box fold
    logic                         r_s3_valid;
    logic [MAG_W-1:0]             r_s3_mag [3];
    logic [MAG_W-1:0]             w_mag [3];

    always_comb begin
        logic [SW-1:0] ext;
        logic [SW-1:0] folded;
        logic [SW-1:0] mag;
        for (int i = 0; i < 3; i++) begin
            ext = SW'(r_s2_abs[i]);
            // fold once past half the box; may go negative, so take magnitude again
            if (ext > SW'(r_box[i][LEN_W-1:1])) begin
                folded = ext - SW'(r_box[i]);
            end else begin
                folded = ext;
            end
            mag      = folded[SW-1] ? (~folded + SW'(1)) : folded;
            w_mag[i] = (mag > MAG_CAP) ? MAG_SAT : mag[MAG_W-1:0];
        end
    end

    // ---------------------------------------------------------------- S4: squares
    logic                         r_s4_valid;
    logic [SQ_W-1:0]              r_s4_sq [3];

    // ---------------------------------------------------------------- S5: r^2
    logic                         r_s5_valid;
    logic [SQ_W-1:0]              r_s5_r2;

    // ---------------------------------------------------------------- S6: zone
    t_sqrt_in                     r_sq_in;
    t_zone                        w_zone;
    t_sqrt_out                    w_sq_out;

    always_comb begin
        // inner test first: it wins when the radii cross
        if (r_s5_r2 <= SQ_W'(r_ri_sq)) begin
            w_zone = ZONE_INSIDE;
        end else if (r_s5_r2 >= SQ_W'(r_ro_sq)) begin
            w_zone = ZONE_OUTSIDE;
        end else begin
            w_zone = ZONE_SHELL;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_p[0]   <= i_point_x;
        r_s1_p[1]   <= i_point_y;
        r_s1_p[2]   <= i_point_z;
        r_s1_c[0]   <= i_center_x;
        r_s1_c[1]   <= i_center_y;
        r_s1_c[2]   <= i_center_z;
        for (int i = 0; i < 3; i++) begin
            r_s2_abs[i] <= w_abs[i];
            r_s3_mag[i] <= w_mag[i];
            r_s4_sq[i]  <= SQ_W'(r_s3_mag[i]) * SQ_W'(r_s3_mag[i]);
        end
        r_s5_r2     <= r_s4_sq[0] + r_s4_sq[1] + r_s4_sq[2];
        r_sq_in.tag <= w_zone;
        // only shell points use the root, and their r^2 is below 2^62
        r_sq_in.rad <= r_s5_r2[RAD_W-1:0];
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_s3_valid    <= 1'b0;
            r_s4_valid    <= 1'b0;
            r_s5_valid    <= 1'b0;
            r_sq_in.valid <= 1'b0;
        end else begin
            r_s1_valid    <= start && !busy;
            r_s2_valid    <= r_s1_valid;
            r_s3_valid    <= r_s2_valid;
            r_s4_valid    <= r_s3_valid;
            r_s5_valid    <= r_s4_valid;
            r_sq_in.valid <= r_s5_valid;
        end
    end

    // ---------------------------------------------------------------- root
    prbw_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (r_sq_in),
        .o_out   (w_sq_out)
    );

    // ---------------------------------------------------------------- S7: shell product
    logic                         r_s7_valid;
    t_zone                        r_s7_zone;
    logic [ROOT_W+SLOPE_W-1:0]    r_s7_prod;

    always_ff @(posedge i_clk) begin
        // root >= r_inner for shell points; other zones ignore the product
        r_s7_prod <= (ROOT_W+SLOPE_W)'(w_sq_out.root - ROOT_W'(r_ri))
                   * (ROOT_W+SLOPE_W)'(r_slope);
        r_s7_zone <= w_sq_out.tag;
        if (!i_rst_n) begin
            r_s7_valid <= 1'b0;
        end else begin
            r_s7_valid <= w_sq_out.valid;
        end
    end

    // ---------------------------------------------------------------- S8: weight
    logic [55:0]          w_round;
    logic [35:0]          w_scaled;
    logic [36:0]          w_sum;
    logic [WEIGHT_W-1:0]  w_shell_w;
    logic [WEIGHT_W-1:0]  w_min_sat;
    logic [WEIGHT_W-1:0]  w_max_sat;
    logic [WEIGHT_W-1:0]  w_weight;

    always_comb begin
        // Q19.36 product, rounded half up to Q1.16
        w_round   = 56'(r_s7_prod) + ROUND_HALF;
        w_scaled  = w_round[55:20];
        w_sum     = 37'(w_scaled) + 37'(r_s_min);
        w_shell_w = (w_sum > 37'(ONE_Q16)) ? ONE_Q16 : w_sum[WEIGHT_W-1:0];
        w_min_sat = (r_s_min > ONE_Q16) ? ONE_Q16 : r_s_min;
        w_max_sat = (r_s_max > ONE_Q16) ? ONE_Q16 : r_s_max;
        case (r_s7_zone)
            ZONE_INSIDE: w_weight = w_min_sat;
            ZONE_SHELL:  w_weight = w_shell_w;
            default:     w_weight = w_max_sat;
        endcase
    end

    always_ff @(posedge i_clk) begin
        o_weight <= w_weight;
        o_zone   <= r_s7_zone;
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_s7_valid;
        end
    end

    // ---------------------------------------------------------------- checks
    `PRBW_IMPLY(a_latency, start && !busy, ##PIPE_LAT o_done, "result strobe missing after fixed latency")
    `PRBW_IMPLY(a_shell_root, w_sq_out.valid && w_sq_out.tag == ZONE_SHELL, w_sq_out.root >= ROOT_W'(r_ri), "shell root below inner radius")
    `PRBW_IMPLY(a_weight_cap, o_done, o_weight <= ONE_Q16, "weight above one")
    `PRBW_IMPLY(a_shell_floor, o_done && o_zone == ZONE_SHELL, o_weight >= ((r_s_min > ONE_Q16) ? ONE_Q16 : r_s_min), "shell weight below s_min")

endmodule

`default_nettype wire

>>> src/prbw_isqrt.sv
`default_nettype none

`include "periodic_radial_blend_weight_macros.svh"

// Pipelined digit-by-digit square root, two result bits per stage.
module prbw_isqrt import prbw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_in  i_in,
    output t_sqrt_out o_out
);

    logic              r_valid [SQRT_STAGES];
    t_zone             r_tag   [SQRT_STAGES];
    logic [RAD_W-1:0]  r_rad   [SQRT_STAGES];
    logic [REM_W-1:0]  r_rem   [SQRT_STAGES];
    logic [ROOT_W-1:0] r_q     [SQRT_STAGES];

    logic              w_valid [SQRT_STAGES];
    t_zone             w_tag   [SQRT_STAGES];
    logic [RAD_W-1:0]  w_rad   [SQRT_STAGES];
    logic [REM_W-1:0]  w_rem   [SQRT_STAGES];
    logic [ROOT_W-1:0] w_q     [SQRT_STAGES];

    logic [RAD_W-1:0]  n_rad   [SQRT_STAGES];
    logic [REM_W-1:0]  n_rem   [SQRT_STAGES];
    logic [ROOT_W-1:0] n_q     [SQRT_STAGES];

    // stage inputs
    always_comb begin
        w_valid[0] = i_in.valid;
        w_tag[0]   = i_in.tag;
        w_rad[0]   = i_in.rad;
        w_rem[0]   = '0;
        w_q[0]     = '0;
        for (int s = 1; s < SQRT_STAGES; s++) begin
            w_valid[s] = r_valid[s-1];
            w_tag[s]   = r_tag[s-1];
            w_rad[s]   = r_rad[s-1];
            w_rem[s]   = r_rem[s-1];
            w_q[s]     = r_q[s-1];
        end
    end

    always_comb begin
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] q;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        for (int s = 0; s < SQRT_STAGES; s++) begin
            rad   = w_rad[s];
            rem   = w_rem[s];
            q     = w_q[s];
            cur   = '0;
            trial = '0;
            for (int j = 0; j < SQRT_PER_STAGE; j++) begin
                if (s * SQRT_PER_STAGE + j < SQRT_ITERS) begin
                    cur   = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                    trial = REM_W'({q, 2'b01});
                    rad   = {rad[RAD_W-3:0], 2'b00};
                    if (cur >= trial) begin
                        rem = cur - trial;
                        q   = {q[ROOT_W-2:0], 1'b1};
                    end else begin
                        rem = cur;
                        q   = {q[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            n_rad[s] = rad;
            n_rem[s] = rem;
            n_q[s]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < SQRT_STAGES; s++) begin
            r_tag[s] <= w_tag[s];
            r_rad[s] <= n_rad[s];
            r_rem[s] <= n_rem[s];
            r_q[s]   <= n_q[s];
        end
        if (!i_rst_n) begin
            for (int s = 0; s < SQRT_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s < SQRT_STAGES; s++) begin
                r_valid[s] <= w_valid[s];
            end
        end
    end

    assign o_out.valid = r_valid[SQRT_STAGES-1];
    assign o_out.tag   = r_tag[SQRT_STAGES-1];
    assign o_out.root  = r_q[SQRT_STAGES-1];

    // remainder of a floor root never exceeds twice the root
    `PRBW_IMPLY(a_rem_bound, r_valid[SQRT_STAGES-1], r_rem[SQRT_STAGES-1] <= REM_W'({r_q[SQRT_STAGES-1], 1'b0}), "sqrt remainder above 2*root")

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import prbw_pkg::*;

    localparam int CB        = 32;
    localparam int N_ROWS    = 28;
    localparam int SEG_BEATS = 166;     // random points per register setting
    localparam int N_SEGS    = 4;       // register settings per idling phase

    // Writes here must be dropped by the block.
    localparam t_cfg_idx REG_UNUSED = 4'd15;

    localparam logic [CB-1:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [CB-1:0] C_MIN = 32'h8000_0000;

    typedef enum logic { ROW_WRITE, ROW_POINT } t_row_kind;

    // One line of the directed table. Point rows with hard_exp set carry their
    // own answer; all other point rows go through the predictor.
    typedef struct packed {
        t_row_kind           kind;
        t_cfg_idx            idx;
        logic [31:0]         data;
        logic [CB-1:0]       px, py, pz, cx, cy, cz;
        logic                hard_exp;
        logic [WEIGHT_W-1:0] w;
        t_zone               z;
    } t_row;

    typedef struct {
        logic [CB-1:0] pt [3];
        logic [CB-1:0] ct [3];
    } t_coords;

    typedef struct packed {
        logic [WEIGHT_W-1:0] w;
        t_zone               z;
    } t_blend;

    // Directed table, walked in order from reset.
    // Rows 1-7 run on reset settings (1 nm box, shell 0..1 nm).
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // coincident points: inside, s_min
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b1, 17'd0, ZONE_INSIDE},
        // exactly half a box: no wrap
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h0008_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        // one LSB past half a box: wraps
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h0008_0001, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        // one LSB short of a box: wraps to a distance of one LSB
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h000F_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'd0, 32'hFFF8_0000, 32'd0, 32'd0, 32'd0,
          32'h0004_0000, 1'b0, 17'd0, ZONE_INSIDE},
        // coordinate extremes: per-axis magnitude saturates
        '{ROW_POINT, REG_BOX_X, 32'd0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
          1'b1, ONE_Q16, ZONE_OUTSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
          1'b1, ONE_Q16, ZONE_OUTSIDE},
        // zero box: half is zero, difference kept
        '{ROW_WRITE, REG_BOX_X, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h0008_0001, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        // full-width data, top bit masked off
        '{ROW_WRITE, REG_BOX_X, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        // inner radius above outer: inside wins
        '{ROW_WRITE, REG_R_INNER, 32'h0020_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h0020_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b1, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h0018_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b1, 17'd0, ZONE_INSIDE},
        // s_min over one: saturates
        '{ROW_WRITE, REG_S_MIN, 32'h0001_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b1, ONE_Q16, ZONE_INSIDE},
        // exactly on the outer radius
        '{ROW_WRITE, REG_R_INNER, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h0010_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b1, ONE_Q16, ZONE_OUTSIDE},
        // widest shell, steepest slope
        '{ROW_WRITE, REG_R_OUTER, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_WRITE, REG_SLOPE, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_WRITE, REG_S_MIN, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h0010_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_WRITE, REG_S_MAX, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN,
          1'b1, 17'd0, ZONE_OUTSIDE},
        // s_max over one: saturates
        '{ROW_WRITE, REG_S_MAX, 32'h0001_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX,
          1'b1, ONE_Q16, ZONE_OUTSIDE},
        // unknown register: must leave the settings alone
        '{ROW_WRITE, REG_UNUSED, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE},
        '{ROW_POINT, REG_BOX_X, 32'd0, 32'h0000_4000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
          1'b0, 17'd0, ZONE_INSIDE}
    };

    // ---------------------------------------------------------------- DUT ports
    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CB-1:0]       i_point_x, i_point_y, i_point_z;
    logic [CB-1:0]       i_center_x, i_center_y, i_center_z;
    logic                o_done;
    logic [WEIGHT_W-1:0] o_weight;
    t_zone               o_zone;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    t_cfg_idx            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    periodic_radial_blend_weight #(.COORD_BITS(CB)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_point_z  (i_point_z),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_center_z (i_center_z),
        .o_done     (o_done),
        .o_weight   (o_weight),
        .o_zone     (o_zone),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // ------------------------------------------------- shadow register file
    logic [LEN_W-1:0]    box_len [3];
    logic [LEN_W-1:0]    r_in, r_out;
    logic [SLOPE_W-1:0]  shell_slope;
    logic [WEIGHT_W-1:0] w_in, w_out;

    t_blend pending_weights [$];    // one per accepted point, oldest first

    int idle_pct;                   // sender idle chance per cycle, percent
    int n_mismatch;
    int n_directed, n_random, n_settings;
    int zone_hits [3];

    // --------------------------------------------------------------- clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("timeout at %0t with %0d results outstanding", $time,
                 pending_weights.size());
        $display("periodic_radial_blend_weight regression: fail");
        $finish;
    end

    // --------------------------------------------------------- predictor
    function automatic logic [WEIGHT_W-1:0] clamp_unit(input logic [63:0] v);
        return (v > 64'(ONE_Q16)) ? ONE_Q16 : v[WEIGHT_W-1:0];
    endfunction

    // Weight and zone for a point/centre pair under the shadow settings.
    function automatic t_blend predict_blend(input t_coords c);
        longint      d;
        longint      bx;
        logic [63:0] mag, r2, root, trial, prod;
        t_blend      res;
        r2 = '0;
        for (int a = 0; a < 3; a++) begin
            d  = longint'($signed(c.pt[a])) - longint'($signed(c.ct[a]));
            bx = longint'(box_len[a]);
            if (d < 0)
                d = -d;
            // minimum image: one box off, no second fold
            if (d > (bx >>> 1))
                d = d - bx;
            if (d < 0)
                d = -d;
            mag = 64'(d);
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            r2 += mag * mag;
        end
        if (r2 <= 64'(r_in) * 64'(r_in)) begin
            res.w = clamp_unit(64'(w_in));
            res.z = ZONE_INSIDE;
        end else if (r2 >= 64'(r_out) * 64'(r_out)) begin
            res.w = clamp_unit(64'(w_out));
            res.z = ZONE_OUTSIDE;
        end else begin
            // r2 < 2^62 here, so the root fits 31 bits
            root = '0;
            for (int b = 31; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= r2)
                    root = trial;
            end
            prod  = (root - 64'(r_in)) * 64'(shell_slope);
            res.w = clamp_unit(((prod + 64'h8_0000) >> 20) + 64'(w_in));
            res.z = ZONE_SHELL;
        end
        return res;
    endfunction

    // ------------------------------------------------------------- drivers
    // Register beat. Waits for the pipe to drain first; leaves valid high so
    // back-to-back writes run without a gap. offer_point drops it.
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        start <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_BOX_X:   box_len[0]  = data[LEN_W-1:0];
            REG_BOX_Y:   box_len[1]  = data[LEN_W-1:0];
            REG_BOX_Z:   box_len[2]  = data[LEN_W-1:0];
            REG_R_INNER: r_in        = data[LEN_W-1:0];
            REG_R_OUTER: r_out       = data[LEN_W-1:0];
            REG_SLOPE:   shell_slope = data[SLOPE_W-1:0];
            REG_S_MIN:   w_in        = data[WEIGHT_W-1:0];
            REG_S_MAX:   w_out       = data[WEIGHT_W-1:0];
            default: ;  // ignored by the block
        endcase
    endtask

    // Point beat, with random idling ahead of it. Expectation is queued at
    // the accepting edge.
    task automatic offer_point(input t_coords c, input logic hard_exp,
                               input logic [WEIGHT_W-1:0] hw, input t_zone hz);
        t_blend due;
        i_cfg_valid <= 1'b0;
        if ($urandom_range(0, 199) == 0) begin
            // hold off until the pipe is empty
            start <= 1'b0;
            do @(posedge i_clk); while (pending_weights.size() != 0);
        end else if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start      <= 1'b1;
        i_point_x  <= c.pt[0];
        i_point_y  <= c.pt[1];
        i_point_z  <= c.pt[2];
        i_center_x <= c.ct[0];
        i_center_y <= c.ct[1];
        i_center_z <= c.ct[2];
        do @(posedge i_clk); while (busy);
        if (hard_exp) begin
            due.w = hw;
            due.z = hz;
        end else begin
            due = predict_blend(c);
        end
        pending_weights.push_back(due);
    endtask

    // Writes every register. Setting 0 of each group of six is the wide
    // extreme, setting 3 the narrow one, the rest random.
    task automatic load_settings(input int k);
        logic [LEN_W-1:0] bx [3];
        logic [LEN_W-1:0] ro, ri;
        logic [31:0]      sl, smin, smax;
        if (k % 6 == 0) begin
            bx = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
            ro = 31'h7FFF_FFFF;
            ri = 31'h0000_0000;
            sl = 32'h00FF_FFFF;
            smin = 32'd0;
            smax = 32'h0001_FFFF;
        end else if (k % 6 == 3) begin
            bx = '{31'd1, 31'd1, 31'd1};
            ro = '0;
            ri = '0;
            sl = 32'd0;
            smin = 32'd0;
            smax = 32'd0;
        end else begin
            for (int a = 0; a < 3; a++) begin
                case ($urandom_range(0, 4))
                    0: bx[a] = 31'h0010_0000;
                    1: bx[a] = LEN_W'($urandom_range(1, 64));
                    2: bx[a] = 31'h7FFF_FFFF;
                    3: bx[a] = LEN_W'($urandom_range(1, 32'h7FFF_FFFF));
                    default: bx[a] = LEN_W'($urandom_range(1, 32'h0100_0000));
                endcase
            end
            ro = LEN_W'($urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
            case ($urandom_range(0, 3))
                0: ri = '0;
                1: ri = ro;
                2: ri = LEN_W'($urandom_range(0, 32'(ro)));
                default: ri = (ro > 31'h7FFF_0000) ? ro : ro + LEN_W'($urandom_range(1, 4096));
            endcase
            sl   = ($urandom & 32'h00FF_FFFF) >> $urandom_range(0, 23);
            smin = ($urandom_range(0, 7) == 0) ? $urandom_range(65537, 131071)
                                               : $urandom_range(0, 65536);
            smax = ($urandom_range(0, 7) == 0) ? $urandom_range(65537, 131071)
                                               : $urandom_range(0, 65536);
        end
        write_reg(REG_BOX_X,   32'(bx[0]));
        write_reg(REG_BOX_Y,   32'(bx[1]));
        write_reg(REG_BOX_Z,   32'(bx[2]));
        write_reg(REG_R_INNER, 32'(ri));
        write_reg(REG_R_OUTER, 32'(ro));
        write_reg(REG_SLOPE,   sl);
        write_reg(REG_S_MIN,   smin);
        write_reg(REG_S_MAX,   smax);
        n_settings++;
    endtask

    // Random point pair. Most land near the shell (and its periodic images),
    // some straddle the half-box line, the rest are raw noise.
    function automatic t_coords random_pair();
        t_coords     c;
        int unsigned mode;
        longint      span, off;
        logic [63:0] u;
        mode = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            c.ct[a] = $urandom;
            if (mode <= 5) begin
                span = longint'(r_out) + longint'(r_out >> 2) + 8;
                u    = {$urandom, $urandom};
                off  = longint'(u % 64'(2 * span + 1)) - span;
                if ($urandom_range(0, 1) == 1)
                    off = off >>> 1;
                if ($urandom_range(0, 3) == 0)
                    off += ($urandom_range(0, 1) == 1) ? longint'(box_len[a])
                                                       : -longint'(box_len[a]);
                c.pt[a] = c.ct[a] + CB'(off);
            end else if (mode <= 7) begin
                off = longint'(box_len[a] >> 1) + longint'($urandom_range(0, 2)) - 1;
                if ($urandom_range(0, 1) == 1)
                    off = -off;
                c.pt[a] = c.ct[a] + CB'(off);
            end else begin
                c.pt[a] = $urandom;
            end
        end
        return c;
    endfunction

    // ------------------------------------------------------------- checker
    // o_done is a one-cycle strobe; the receiver has no say in it.
    always @(posedge i_clk) begin : result_check
        t_blend due;
        if (i_rst_n && o_done) begin
            if (pending_weights.size() == 0) begin
                n_mismatch++;
                $display("%0t: unexpected result weight=%0d zone=%0d", $time,
                         o_weight, o_zone);
            end else begin
                due = pending_weights.pop_front();
                if (o_weight !== due.w) begin
                    n_mismatch++;
                    $display("%0t: weight mismatch: expected %0d actual %0d", $time,
                             due.w, o_weight);
                end
                if (o_zone !== due.z) begin
                    n_mismatch++;
                    $display("%0t: zone mismatch: expected %0d actual %0d", $time,
                             due.z, o_zone);
                end
                if (due.z <= ZONE_OUTSIDE)
                    zone_hits[due.z]++;
            end
        end
    end

    // ----------------------------------------------------------- sequence
    initial begin : main_seq
        t_coords c;
        t_row    row;

        // reset values of the register file
        box_len     = '{31'h0010_0000, 31'h0010_0000, 31'h0010_0000};
        r_in        = '0;
        r_out       = 31'h0010_0000;
        shell_slope = 24'h01_0000;
        w_in        = '0;
        w_out       = ONE_Q16;
        n_mismatch  = 0;
        n_directed  = 0;
        n_random    = 0;
        n_settings  = 0;
        zone_hits   = '{0, 0, 0};
        idle_pct    = 33;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_point_x   <= '0;
        i_point_y   <= '0;
        i_point_z   <= '0;
        i_center_x  <= '0;
        i_center_y  <= '0;
        i_center_z  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_BOX_X;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_ROWS; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.idx, row.data);
            end else begin
                c.pt = '{row.px, row.py, row.pz};
                c.ct = '{row.cx, row.cy, row.cz};
                offer_point(c, row.hard_exp, row.w, row.z);
                n_directed++;
            end
        end

        // random part: three idling regimes, several settings in each
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 33 : (ph == 1) ? 63 : 0;
            for (int s = 0; s < N_SEGS; s++) begin
                load_settings(ph * N_SEGS + s);
                repeat (SEG_BEATS) begin
                    offer_point(random_pair(), 1'b0, '0, ZONE_INSIDE);
                    n_random++;
                end
            end
        end

        start       <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (pending_weights.size() != 0)
            @(posedge i_clk);
        // nothing further may strobe out
        repeat (PIPE_LAT + 4) @(posedge i_clk);

        $display("covered %0d directed and %0d random points over %0d register settings",
                 n_directed, n_random, n_settings + 1);
        $display("zones seen: inside %0d, shell %0d, outside %0d; mismatches %0d",
                 zone_hits[0], zone_hits[1], zone_hits[2], n_mismatch);
        if (n_mismatch == 0)
            $display("periodic_radial_blend_weight regression: pass");
        else
            $display("periodic_radial_blend_weight regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/prbw_pkg.sv
src/prbw_isqrt.sv
src/periodic_radial_blend_weight.sv
bench/tb.sv
